### hw/rtl/lmfr_pkg.sv
// Package for the LED matrix frame refresh block: sizes, request codes,
// result kinds, and the word and command types. No dependencies.
`default_nettype none

package lmfr_pkg;

    // Chain geometry.
    localparam int MATRICES        = 2;
    localparam int ROWS_PER_MATRIX = 8;
    localparam int GLOBAL_ROWS     = ROWS_PER_MATRIX * MATRICES;
    localparam int GR_W            = (GLOBAL_ROWS > 1) ? $clog2(GLOBAL_ROWS) : 1;
    localparam int MAT_W           = (MATRICES > 1) ? $clog2(MATRICES) : 1;

    // Command queue between the front and back ends.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Request codes on the input word.
    localparam logic [2:0] REQ_SET_PIXEL = 3'd0;
    localparam logic [2:0] REQ_CLR_PIXEL = 3'd1;
    localparam logic [2:0] REQ_GET_PIXEL = 3'd2;
    localparam logic [2:0] REQ_WRITE_ROW = 3'd3;
    localparam logic [2:0] REQ_CLR_ROWS  = 3'd4;
    localparam logic [2:0] REQ_READ_ROWS = 3'd5;
    localparam logic [2:0] REQ_REFRESH   = 3'd6;

    // Result kinds on the output word.
    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_ROW     = 2'd1;
    localparam logic [1:0] KIND_DISPLAY = 2'd2;

    localparam logic [3:0] DIGIT_ADDR_LAST = 4'(ROWS_PER_MATRIX);

    typedef struct packed {
        logic [2:0] req_type;
        logic [2:0] column;
        logic [2:0] row;
        logic       matrix;
        logic [7:0] row_byte;
        logic [3:0] first_row;
        logic [3:0] final_row;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic       pixel_value;
        logic [7:0] row_value;
        logic [3:0] digit_addr;
        logic [7:0] digit_data;
        logic       latch_after;
        logic       last;
    } t_res;

    typedef enum logic [2:0] {
        OP_SET,
        OP_CLR,
        OP_GET,
        OP_WRITE,
        OP_CLEAR,
        OP_READ,
        OP_REFRESH
    } t_op;

    // Classified command. For single-row operations lo is the global row.
    typedef struct packed {
        t_op             op;
        logic            pix_ok;
        logic [2:0]      column;
        logic [7:0]      data;
        logic [GR_W-1:0] lo;
        logic [GR_W-1:0] hi;
    } t_cmd;

endpackage

`default_nettype wire

### hw/rtl/lmfr_if.sv
// Valid/ready channel interfaces for request and result words.
// Depends on lmfr_pkg.
`default_nettype none

interface lmfr_req_if import lmfr_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lmfr_res_if import lmfr_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/lmfr_front.sv
// Front end: accepts request words and turns them into queue commands.
// Depends on lmfr_pkg and lmfr_if.
`default_nettype none

module lmfr_front import lmfr_pkg::*; (
    lmfr_req_if.sink   i_req,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam logic [7:0] GLOBAL_ROWS_B = 8'(GLOBAL_ROWS);
    localparam logic [7:0] LAST_ROW_B    = 8'(GLOBAL_ROWS - 1);

    logic [7:0] idx8;
    logic [7:0] first8;
    logic [7:0] final8;
    logic       idx_ok;
    logic       range_ok;
    logic       keep;

    assign i_req.ready = !i_full;

    always_comb begin
        idx8   = {4'b0, i_req.data.matrix, i_req.data.row};
        idx_ok = idx8 < GLOBAL_ROWS_B;
        first8 = {4'b0, i_req.data.first_row};
        final8 = {4'b0, i_req.data.final_row};
        // A range is cut at the last row of the store.
        if (final8 > LAST_ROW_B) begin
            final8 = LAST_ROW_B;
        end
        range_ok = first8 <= final8;

        o_cmd.pix_ok = idx_ok;
        o_cmd.column = i_req.data.column;
        o_cmd.data   = i_req.data.row_byte;
        o_cmd.lo     = GR_W'(idx8);
        o_cmd.hi     = GR_W'(final8);
        o_cmd.op     = OP_SET;
        keep         = 1'b0;

        unique case (i_req.data.req_type)
            REQ_SET_PIXEL: begin
                o_cmd.op = OP_SET;
                keep     = idx_ok;
            end
            REQ_CLR_PIXEL: begin
                o_cmd.op = OP_CLR;
                keep     = idx_ok;
            end
            REQ_GET_PIXEL: begin
                // Always answered; an out-of-chain pixel reads as zero.
                o_cmd.op = OP_GET;
                keep     = 1'b1;
            end
            REQ_WRITE_ROW: begin
                o_cmd.op = OP_WRITE;
                keep     = idx_ok;
            end
            REQ_CLR_ROWS: begin
                o_cmd.op = OP_CLEAR;
                o_cmd.lo = GR_W'(first8);
                keep     = range_ok;
            end
            REQ_READ_ROWS: begin
                o_cmd.op = OP_READ;
                o_cmd.lo = GR_W'(first8);
                keep     = range_ok;
            end
            REQ_REFRESH: begin
                o_cmd.op = OP_REFRESH;
                keep     = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Requests with no effect are taken and dropped here.
    assign o_push = i_req.valid && !i_full && keep;

endmodule

`default_nettype wire

### hw/rtl/lmfr_cmd_fifo.sv
// Short command queue between the front and back ends.
// Depends on lmfr_pkg.
`default_nettype none

module lmfr_cmd_fifo import lmfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = r_count == Q_CNT_W'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lmfr_back.sv
// Back end: holds the frame store and executes queued commands into a registered
// result word, one row per cycle unless stalled. Depends on lmfr_pkg, lmfr_if.
`default_nettype none

module lmfr_back import lmfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    lmfr_res_if.source  o_res
);

    localparam logic [MAT_W-1:0] MAT_TOP = MAT_W'(MATRICES - 1);
    localparam logic [2:0]       ROW_TOP = 3'(ROWS_PER_MATRIX - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_REFRESH
    } t_state;

    t_state          r_state;
    logic [7:0]      r_store [GLOBAL_ROWS];
    logic [GR_W-1:0] r_cur;
    logic [GR_W-1:0] r_end;
    logic [2:0]      r_row;
    logic [MAT_W-1:0] r_mat;
    logic            r_ov;
    t_res            r_res;

    logic            can_emit;
    logic            emit;
    logic [GR_W-1:0] rd_idx;
    logic [7:0]      rd_byte;
    logic [7:0]      mask;
    logic            refresh_last;

    assign can_emit = !r_ov || o_res.ready;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_res;
    assign mask = 8'h80 >> i_cmd.column;
    assign refresh_last = (r_mat == '0) && (r_row == ROW_TOP);

    // A new result word is loaded into the result register in this cycle.
    assign emit = ((r_state == ST_IDLE) && o_pop && (i_cmd.op == OP_GET))
                || (((r_state == ST_READ) || (r_state == ST_REFRESH)) && can_emit);

    always_comb begin
        unique case (r_state)
            ST_IDLE:    rd_idx = i_cmd.lo;
            ST_CLEAR:   rd_idx = r_cur;
            ST_READ:    rd_idx = r_cur;
            ST_REFRESH: rd_idx = GR_W'({r_mat, r_row});
            default:    rd_idx = r_cur;
        endcase
        rd_byte = r_store[rd_idx];
    end

    // A pixel read waits until the result register can take its word.
    always_comb begin
        o_pop = 1'b0;
        if (r_state == ST_IDLE && i_cmd_valid) begin
            o_pop = (i_cmd.op == OP_GET) ? can_emit : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_store <= '{default: '0};
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        unique case (i_cmd.op)
                            OP_SET:   r_store[i_cmd.lo] <= rd_byte | mask;
                            OP_CLR:   r_store[i_cmd.lo] <= rd_byte & ~mask;
                            OP_WRITE: r_store[i_cmd.lo] <= i_cmd.data;
                            OP_GET: begin
                                r_res <= '{kind: KIND_PIXEL,
                                           pixel_value: i_cmd.pix_ok && ((rd_byte & mask) != '0),
                                           row_value: '0, digit_addr: '0, digit_data: '0,
                                           latch_after: 1'b0, last: 1'b1};
                            end
                            OP_CLEAR: begin
                                r_cur   <= i_cmd.lo;
                                r_end   <= i_cmd.hi;
                                r_state <= ST_CLEAR;
                            end
                            OP_READ: begin
                                r_cur   <= i_cmd.lo;
                                r_end   <= i_cmd.hi;
                                r_state <= ST_READ;
                            end
                            OP_REFRESH: begin
                                r_row   <= '0;
                                r_mat   <= MAT_TOP;
                                r_state <= ST_REFRESH;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CLEAR: begin
                    r_store[r_cur] <= '0;
                    if (r_cur == r_end) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_cur <= r_cur + GR_W'(1);
                    end
                end
                ST_READ: begin
                    if (can_emit) begin
                        r_res <= '{kind: KIND_ROW, pixel_value: 1'b0, row_value: rd_byte,
                                   digit_addr: '0, digit_data: '0, latch_after: 1'b0,
                                   last: r_cur == r_end};
                        if (r_cur == r_end) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_cur <= r_cur + GR_W'(1);
                        end
                    end
                end
                ST_REFRESH: begin
                    if (can_emit) begin
                        r_res <= '{kind: KIND_DISPLAY, pixel_value: 1'b0, row_value: '0,
                                   digit_addr: 4'(r_row) + 4'd1, digit_data: rd_byte,
                                   latch_after: r_mat == '0, last: refresh_last};
                        // Last matrix first, then step to the next row address.
                        if (r_mat == '0) begin
                            r_mat <= MAT_TOP;
                            r_row <= r_row + 3'd1;
                            if (r_row == ROW_TOP) begin
                                r_state <= ST_IDLE;
                            end
                        end else begin
                            r_mat <= r_mat - MAT_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/led_matrix_frame_refresh.sv
// Top level of the LED matrix frame refresh block: front end, command
// queue and back end. Depends on lmfr_pkg, lmfr_if and the three submodules.
//
// Usage. Requests arrive as words on i_req (valid/ready); results leave as
// words on o_res (valid/ready). A word is accepted at a rising edge where
// valid and ready are both high. The frame store holds eight row bytes for
// each cascaded matrix; global row = 8*matrix + row, column 0 is bit 7.
// Set, clear and write requests and row-range clears return nothing; a pixel
// read returns one word, a range read one word per row, and a refresh one
// display word per matrix for each of the eight row addresses.
// The back end handles one store row per cycle unless a stalled result
// word holds it. The two-entry command queue lets the front end take
// requests while the back end works; i_req.ready drops only when that
// queue is full.
// When the receiver stalls, the result register holds its word and the back
// end waits at the next command that returns a word; the queue then fills
// and backpressure reaches i_req.
// Reset (synchronous, active low) clears the frame store to zero at once,
// empties the queue and drops o_res.valid.
`default_nettype none

module led_matrix_frame_refresh import lmfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmfr_req_if.sink   i_req,
    lmfr_res_if.source o_res
);

    logic push;
    logic full;
    logic pop;
    logic cmd_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    lmfr_front u_front (
        .i_req  (i_req),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    lmfr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd)
    );

    lmfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

### hw/rtl/lmfr_checker.sv
// Port-level checks on the result channel of the frame refresh block,
// bound to the top level. Depends on lmfr_pkg.
`default_nettype none

module lmfr_checker import lmfr_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_res_valid,
    input logic i_res_ready,
    input t_res i_res_data
);

    // A stalled result word stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("result word changed while stalled");

    // Nothing is shown right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // A pixel read is always a single, final word.
    a_pixel_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.kind == KIND_PIXEL |-> i_res_data.last)
        else $error("pixel read not marked last");

    // A refresh ends on matrix 0 of the last row address.
    a_refresh_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.kind == KIND_DISPLAY && i_res_data.last
        |-> i_res_data.latch_after && i_res_data.digit_addr == DIGIT_ADDR_LAST)
        else $error("refresh ended on the wrong word");

    // Display words carry a row address from 1 to 8.
    a_digit_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.kind == KIND_DISPLAY
        |-> i_res_data.digit_addr != 4'd0 && i_res_data.digit_addr <= DIGIT_ADDR_LAST)
        else $error("display word row address out of range");

endmodule

bind led_matrix_frame_refresh lmfr_checker u_lmfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);

`default_nettype wire

### bench/lmfr_result_check.sv
// Watches the request and result channels of the LED matrix frame refresh block,
// keeps its own image of the frame store and checks every result word.
// Depends on lmfr_pkg and lmfr_if.
`timescale 1ns / 1ps

module lmfr_result_check import lmfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lmfr_req_if  i_req,
    lmfr_res_if  i_res,
    output int   o_fail_count,
    output int   o_words_due
);

    logic [7:0] frame_image [GLOBAL_ROWS];
    t_res       words_due [$];
    int         fail_total = 0;
    int         due_total  = 0;

    assign o_fail_count = fail_total;
    assign o_words_due  = due_total;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_total++;
    endtask

    task automatic compare_field(string what, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Applies one accepted request to the frame image and queues the words it returns.
    function automatic void predict_request(t_req r);
        int unsigned g_row;
        int unsigned lo;
        int unsigned hi;
        int          g;
        int          addr;
        int          m;
        logic [7:0]  bit_mask;
        t_res        w;
        g_row    = ROWS_PER_MATRIX * r.matrix + r.row;
        bit_mask = 8'h80 >> r.column;
        lo       = r.first_row;
        hi       = (r.final_row > GLOBAL_ROWS - 1) ? GLOBAL_ROWS - 1 : r.final_row;
        case (r.req_type)
            REQ_SET_PIXEL: begin
                if (g_row < GLOBAL_ROWS) frame_image[g_row] = frame_image[g_row] | bit_mask;
            end
            REQ_CLR_PIXEL: begin
                if (g_row < GLOBAL_ROWS) frame_image[g_row] = frame_image[g_row] & ~bit_mask;
            end
            REQ_GET_PIXEL: begin
                w             = '0;
                w.kind        = KIND_PIXEL;
                w.pixel_value = (g_row < GLOBAL_ROWS) && ((frame_image[g_row] & bit_mask) != 0);
                w.last        = 1'b1;
                words_due.push_back(w);
            end
            REQ_WRITE_ROW: begin
                if (g_row < GLOBAL_ROWS) frame_image[g_row] = r.row_byte;
            end
            REQ_CLR_ROWS: begin
                for (g = lo; g <= hi; g++) frame_image[g] = '0;
            end
            REQ_READ_ROWS: begin
                for (g = lo; g <= hi; g++) begin
                    w           = '0;
                    w.kind      = KIND_ROW;
                    w.row_value = frame_image[g];
                    w.last      = (g == hi);
                    words_due.push_back(w);
                end
            end
            REQ_REFRESH: begin
                for (addr = 1; addr <= ROWS_PER_MATRIX; addr++) begin
                    for (m = MATRICES - 1; m >= 0; m--) begin
                        w             = '0;
                        w.kind        = KIND_DISPLAY;
                        w.digit_addr  = 4'(addr);
                        w.digit_data  = frame_image[m * ROWS_PER_MATRIX + addr - 1];
                        w.latch_after = (m == 0);
                        w.last        = (addr == ROWS_PER_MATRIX) && (m == 0);
                        words_due.push_back(w);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic check_word(t_res got);
        t_res want;
        if (words_due.size() == 0) begin
            report_mismatch("result word with nothing expected", 32'(got), 32'd0);
            return;
        end
        want = words_due.pop_front();
        compare_field("kind",        8'(got.kind),        8'(want.kind));
        compare_field("pixel_value", 8'(got.pixel_value), 8'(want.pixel_value));
        compare_field("row_value",   got.row_value,       want.row_value);
        compare_field("digit_addr",  8'(got.digit_addr),  8'(want.digit_addr));
        compare_field("digit_data",  got.digit_data,      want.digit_data);
        compare_field("latch_after", 8'(got.latch_after), 8'(want.latch_after));
        compare_field("last",        8'(got.last),        8'(want.last));
    endtask

    // Results are checked before the request of the same edge is predicted;
    // a result never belongs to a request accepted at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (frame_image[g]) frame_image[g] = '0;
            words_due.delete();
        end else begin
            if (i_res.valid && i_res.ready) check_word(i_res.data);
            if (i_req.valid && i_req.ready) predict_request(i_req.data);
        end
        due_total = words_due.size();
    end

endmodule

### bench/led_matrix_frame_refresh_test.sv
// Top of the testbench for the LED matrix frame refresh block: clock, reset,
// request stimulus, result back-pressure and the verdict.
// Depends on lmfr_pkg, lmfr_if, the block itself and lmfr_result_check.
`timescale 1ns / 1ps

module led_matrix_frame_refresh_test;
    import lmfr_pkg::*;

    // Request code 7 has no meaning; the block must swallow it without a result.
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    // Length of the one long receiver hold-off. It is far longer than the
    // command queue plus the result register can absorb, so the request
    // channel is certain to back up while it lasts.
    localparam int LONG_HOLD_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;

    lmfr_req_if req_ch ();
    lmfr_res_if res_ch ();

    int fail_count;
    int words_due;

    // Idle controls shared by the sender (main initial) and the receiver process.
    bit sender_idles   = 1'b0;
    bit receiver_idles = 1'b0;
    bit long_hold_due  = 1'b0;

    led_matrix_frame_refresh dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    lmfr_result_check u_result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Gap lengths: one draw in ten picks from the long range, the others from the short one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic t_req make_req(logic [2:0] code, logic [2:0] column, logic [2:0] row,
                                      logic matrix, logic [7:0] row_byte,
                                      logic [3:0] first_row, logic [3:0] final_row);
        t_req r;
        r.req_type  = code;
        r.column    = column;
        r.row       = row;
        r.matrix    = matrix;
        r.row_byte  = row_byte;
        r.first_row = first_row;
        r.final_row = final_row;
        return r;
    endfunction

    // Every field starts from random bits so that each bit toggles. Ranges
    // are mostly well ordered so that reads and clears actually do work;
    // clears are kept short so the frame does not stay blank. About one
    // range in ten keeps its raw random bounds and may come out reversed.
    function automatic t_req random_request();
        t_req r;
        int   pick;
        r    = t_req'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 20)      r.req_type = REQ_SET_PIXEL;
        else if (pick < 32) r.req_type = REQ_CLR_PIXEL;
        else if (pick < 47) r.req_type = REQ_GET_PIXEL;
        else if (pick < 62) r.req_type = REQ_WRITE_ROW;
        else if (pick < 70) r.req_type = REQ_CLR_ROWS;
        else if (pick < 84) r.req_type = REQ_READ_ROWS;
        else if (pick < 97) r.req_type = REQ_REFRESH;
        else                r.req_type = REQ_UNUSED;
        if ($urandom_range(0, 9) != 0) begin
            r.first_row = 4'($urandom_range(0, GLOBAL_ROWS - 1));
            if (r.req_type == REQ_CLR_ROWS) begin
                r.final_row = 4'($urandom_range(r.first_row, r.first_row + 3));
                if (r.final_row < r.first_row) r.final_row = 4'(GLOBAL_ROWS - 1);
            end else begin
                r.final_row = 4'($urandom_range(r.first_row, GLOBAL_ROWS - 1));
            end
        end
        return r;
    endfunction

    // Offers one word at the current falling edge and holds it until it is
    // taken. On return the clock is at a falling edge; valid is still high
    // unless a gap was inserted, so a caller that stops sending lowers it.
    task automatic send_request(t_req r);
        int gap;
        req_ch.data  = r;
        req_ch.valid = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        if (sender_idles && $urandom_range(0, 2) == 0) begin
            gap          = pick_gap();
            req_ch.valid = 1'b0;
            req_ch.data  = t_req'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Receiver: ready changes only at falling edges. The long hold-off is
    // requested by the main process and counted out here.
    initial begin
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                stall_left    = LONG_HOLD_CYCLES;
            end else if (stall_left == 0 && receiver_idles && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                res_ch.ready = 1'b0;
                stall_left--;
            end else begin
                res_ch.ready = 1'b1;
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int n;
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, no idling on either side. The store starts blank.
        // Column 0 lands on bit 7 and column 7 on bit 0; both matrices and
        // both row extremes are touched.
        send_request(make_req(REQ_SET_PIXEL, 3'd0, 3'd0, 1'b0, 8'h00, 4'd0, 4'd0));
        send_request(make_req(REQ_SET_PIXEL, 3'd7, 3'd7, 1'b1, 8'h00, 4'd0, 4'd0));
        send_request(make_req(REQ_GET_PIXEL, 3'd0, 3'd0, 1'b0, 8'h00, 4'd0, 4'd0));
        send_request(make_req(REQ_GET_PIXEL, 3'd7, 3'd7, 1'b1, 8'h00, 4'd0, 4'd0));
        send_request(make_req(REQ_GET_PIXEL, 3'd1, 3'd0, 1'b0, 8'h00, 4'd0, 4'd0));
        send_request(make_req(REQ_CLR_PIXEL, 3'd0, 3'd0, 1'b0, 8'h00, 4'd0, 4'd0));
        send_request(make_req(REQ_GET_PIXEL, 3'd0, 3'd0, 1'b0, 8'h00, 4'd0, 4'd0));
        send_request(make_req(REQ_WRITE_ROW, 3'd0, 3'd3, 1'b0, 8'hFF, 4'd0, 4'd0));
        send_request(make_req(REQ_WRITE_ROW, 3'd0, 3'd7, 1'b1, 8'hA5, 4'd0, 4'd0));
        send_request(make_req(REQ_WRITE_ROW, 3'd0, 3'd0, 1'b1, 8'h5A, 4'd0, 4'd0));
        send_request(make_req(REQ_WRITE_ROW, 3'd0, 3'd5, 1'b0, 8'h81, 4'd0, 4'd0));
        // Whole-store read, single-row read at the top, and a reversed range
        // that must return nothing.
        send_request(make_req(REQ_READ_ROWS, 3'd0, 3'd0, 1'b0, 8'h00, 4'd0, 4'd15));
        send_request(make_req(REQ_READ_ROWS, 3'd0, 3'd0, 1'b0, 8'h00, 4'd15, 4'd15));
        send_request(make_req(REQ_READ_ROWS, 3'd0, 3'd0, 1'b0, 8'h00, 4'd5, 4'd2));
        send_request(make_req(REQ_REFRESH,   3'd0, 3'd0, 1'b0, 8'h00, 4'd0, 4'd0));
        // A reversed clear must leave the store alone; the next one spans
        // the boundary between the two matrices.
        send_request(make_req(REQ_CLR_ROWS,  3'd0, 3'd0, 1'b0, 8'h00, 4'd9, 4'd3));
        send_request(make_req(REQ_CLR_ROWS,  3'd0, 3'd0, 1'b0, 8'h00, 4'd3, 4'd8));
        send_request(make_req(REQ_GET_PIXEL, 3'd0, 3'd3, 1'b0, 8'h00, 4'd0, 4'd0));
        send_request(make_req(REQ_UNUSED,    3'd7, 3'd7, 1'b1, 8'hFF, 4'd15, 4'd15));
        send_request(make_req(REQ_REFRESH,   3'd0, 3'd0, 1'b0, 8'h00, 4'd0, 4'd0));
        send_request(make_req(REQ_CLR_ROWS,  3'd0, 3'd0, 1'b0, 8'h00, 4'd0, 4'd15));
        send_request(make_req(REQ_READ_ROWS, 3'd0, 3'd0, 1'b0, 8'h00, 4'd0, 4'd15));
        send_request(make_req(REQ_GET_PIXEL, 3'd7, 3'd7, 1'b1, 8'h00, 4'd0, 4'd0));

        // Random traffic with gaps on both sides.
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        for (n = 0; n < 150; n++) send_request(random_request());

        // A stretch with no idling at all.
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        for (n = 0; n < 60; n++) send_request(random_request());

        // The receiver holds off for a long stretch while words keep coming,
        // so the queue fills and the request channel stalls. Afterwards the
        // sender waits until every outstanding result has been delivered.
        long_hold_due = 1'b1;
        for (n = 0; n < 30; n++) send_request(random_request());
        req_ch.valid = 1'b0;
        while (words_due != 0) @(negedge i_clk);

        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        for (n = 0; n < 120; n++) send_request(random_request());
        req_ch.valid = 1'b0;

        // Drain, then keep the clock running for any stray word to show up.
        while (words_due != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Run limit: a run that has not finished by this time fails.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
hw/rtl/lmfr_pkg.sv
hw/rtl/lmfr_if.sv
hw/rtl/lmfr_front.sv
hw/rtl/lmfr_cmd_fifo.sv
hw/rtl/lmfr_back.sv
hw/rtl/led_matrix_frame_refresh.sv
hw/rtl/lmfr_checker.sv
bench/lmfr_result_check.sv
bench/led_matrix_frame_refresh_test.sv
